// ----- sv/tcw_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types for the text console writer.
// No dependencies; every other file but tcw_ram refers to it by scoped names.
package tcw_pkg;

    // Screen geometry
    localparam int unsigned COLUMNS   = 80;
    localparam int unsigned ROWS      = 25;
    localparam int unsigned CELLS     = COLUMNS * ROWS;
    localparam int unsigned CELL_W    = $clog2(CELLS);
    localparam int unsigned COL_W     = $clog2(COLUMNS);
    localparam int unsigned LAST_BASE = (ROWS - 1) * COLUMNS;
    localparam int unsigned COPY_CNT  = CELLS - COLUMNS;

    // Port field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned INDEX_W  = 11;
    localparam int unsigned CURSOR_W = 11;
    localparam int unsigned DATA_W   = 2 * BYTE_W;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    // Character and attribute constants
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [BYTE_W-1:0] BLANK_ATTR   = 8'h02;
    localparam logic [BYTE_W-1:0] PROMPT_CHAR  = 8'h3E;
    localparam logic [BYTE_W-1:0] PROMPT_ATTR  = 8'h07;
    localparam logic [BYTE_W-1:0] BLINK_BIT    = 8'h80;

    // Finished result from the controller to the output stage
    typedef struct packed {
        logic                valid;
        logic [CURSOR_W-1:0] cursor;
        logic [BYTE_W-1:0]   ch;
        logic [BYTE_W-1:0]   attr;
    } result_t;

endpackage

// ----- sv/tcw_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/tcw_ctrl.sv -----
`timescale 1ns / 1ps
// Command sequencer: cursor registers, cell memory, scroll/clear sweeps.
// Depends on tcw_pkg and tcw_ram.
module tcw_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tcw_pkg::CMD_W-1:0]      command,
    input  logic [tcw_pkg::BYTE_W-1:0]     char_code,
    input  logic [tcw_pkg::BYTE_W-1:0]     colors,
    input  logic [tcw_pkg::BYTE_W-1:0]     blink_char,
    input  logic [tcw_pkg::INDEX_W-1:0]    cell_index,
    input  logic                           res_ready,
    output tcw_pkg::result_t               res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DONE   = 3'd1;
    localparam logic [2:0] S_SCROLL = 3'd2;
    localparam logic [2:0] S_TAIL   = 3'd3;
    localparam logic [2:0] S_CLEAR  = 3'd4;
    localparam logic [2:0] S_PROMPT = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_READ   = 3'd7;

    localparam int unsigned CW = tcw_pkg::CELL_W;
    localparam int unsigned KW = tcw_pkg::COL_W;
    localparam int unsigned BW = tcw_pkg::BYTE_W;

    logic [2:0]                   state_reg, state_next;
    logic [CW-1:0]                cursor_reg, cursor_next;
    logic [CW-1:0]                base_reg, base_next;
    logic [KW-1:0]                col_reg, col_next;
    logic [CW-1:0]                ptr_reg, ptr_next;
    logic                         wr_pend_reg, wr_pend_next;
    logic [CW-1:0]                wr_addr_reg, wr_addr_next;
    logic [BW-1:0]                rd_char_reg, rd_char_next;
    logic [BW-1:0]                rd_attr_reg, rd_attr_next;

    logic                         ram_we;
    logic [CW-1:0]                ram_waddr;
    logic [tcw_pkg::DATA_W-1:0]   ram_wdata;
    logic [CW-1:0]                ram_raddr;
    logic [tcw_pkg::DATA_W-1:0]   ram_rdata;

    logic                         idx_ok;
    logic [CW-1:0]                idx_cut;
    logic                         at_last_row;
    logic [BW-1:0]                attr_eff;

    tcw_ram #(
        .WIDTH (tcw_pkg::DATA_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_ok      = 32'(cell_index) < 32'(tcw_pkg::CELLS);
    assign idx_cut     = CW'(cell_index);
    assign at_last_row = base_reg == CW'(tcw_pkg::LAST_BASE);
    assign attr_eff    = (char_code == blink_char) ? (colors | tcw_pkg::BLINK_BIT) : colors;

    assign in_ready   = state_reg == S_IDLE;
    assign res.valid  = state_reg == S_DONE;
    assign res.cursor = tcw_pkg::CURSOR_W'(cursor_reg);
    assign res.ch     = rd_char_reg;
    assign res.attr   = rd_attr_reg;

    always_comb
    begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        base_next    = base_reg;
        col_next     = col_reg;
        ptr_next     = ptr_reg;
        wr_pend_next = wr_pend_reg;
        wr_addr_next = wr_addr_reg;
        rd_char_next = rd_char_reg;
        rd_attr_next = rd_attr_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rd_char_next = '0;
                    rd_attr_next = '0;
                    state_next   = S_DONE;
                    unique case (command)
                        tcw_pkg::CMD_PUT:
                        begin
                            if (char_code != tcw_pkg::NEWLINE_CHAR)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cursor_reg;
                                ram_wdata = {attr_eff, char_code};
                            end
                            if (char_code != tcw_pkg::NEWLINE_CHAR
                                && col_reg != KW'(tcw_pkg::COLUMNS - 1))
                            begin
                                cursor_next = cursor_reg + CW'(1);
                                col_next    = col_reg + KW'(1);
                            end
                            else if (at_last_row)
                            begin
                                // bottom row: cursor to its start, then scroll
                                cursor_next  = CW'(tcw_pkg::LAST_BASE);
                                col_next     = '0;
                                ptr_next     = '0;
                                wr_pend_next = 1'b0;
                                state_next   = S_SCROLL;
                            end
                            else
                            begin
                                base_next   = base_reg + CW'(tcw_pkg::COLUMNS);
                                cursor_next = base_reg + CW'(tcw_pkg::COLUMNS);
                                col_next    = '0;
                            end
                        end
                        tcw_pkg::CMD_CLEAR:
                        begin
                            ptr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        tcw_pkg::CMD_REMOVE:
                        begin
                            if (idx_ok)
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = idx_cut;
                                ram_wdata   = {tcw_pkg::BLANK_ATTR, tcw_pkg::BLANK_CHAR};
                                cursor_next = idx_cut;
                                ptr_next    = idx_cut;
                                base_next   = '0;
                                state_next  = S_DIV;
                            end
                        end
                        tcw_pkg::CMD_READ:
                        begin
                            if (idx_ok)
                            begin
                                ram_raddr  = idx_cut;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCROLL:
            begin
                // read row below, write it back one row up in the following cycle
                if (wr_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata;
                end
                ram_raddr    = ptr_reg + CW'(tcw_pkg::COLUMNS);
                wr_addr_next = ptr_reg;
                wr_pend_next = 1'b1;
                if (ptr_reg == CW'(tcw_pkg::COPY_CNT - 1))
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            S_TAIL:
            begin
                ram_we       = 1'b1;
                ram_waddr    = wr_addr_reg;
                ram_wdata    = ram_rdata;
                wr_pend_next = 1'b0;
                state_next   = S_DONE;
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = {tcw_pkg::BLANK_ATTR, tcw_pkg::BLANK_CHAR};
                if (ptr_reg == CW'(tcw_pkg::CELLS - 1))
                begin
                    state_next = S_PROMPT;
                end
                else
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            S_PROMPT:
            begin
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wdata   = {tcw_pkg::PROMPT_ATTR, tcw_pkg::PROMPT_CHAR};
                cursor_next = CW'(1);
                base_next   = '0;
                col_next    = KW'(1);
                state_next  = S_DONE;
            end
            S_DIV:
            begin
                // one row per cycle: split the new cursor into row base and column
                if (ptr_reg >= CW'(tcw_pkg::COLUMNS))
                begin
                    ptr_next  = ptr_reg - CW'(tcw_pkg::COLUMNS);
                    base_next = base_reg + CW'(tcw_pkg::COLUMNS);
                end
                else
                begin
                    col_next   = KW'(ptr_reg);
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                rd_char_next = ram_rdata[BW-1:0];
                rd_attr_next = ram_rdata[tcw_pkg::DATA_W-1:BW];
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cursor_reg  <= '0;
            base_reg    <= '0;
            col_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            base_reg    <= base_next;
            col_reg     <= col_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        wr_addr_reg <= wr_addr_next;
        rd_char_reg <= rd_char_next;
        rd_attr_reg <= rd_attr_next;
    end

endmodule

// ----- sv/text_console_writer.sv -----
`timescale 1ns / 1ps
// Top level of the text console writer: sequencer plus output word register.
// Depends on tcw_pkg and tcw_ctrl (which holds the cell RAM).
//
//  channel | handshake          | word fields
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_ready  | command char_code colors blink_char cell_index
//  out     | out_valid/out_ready| cursor_position cell_char cell_attr
//
// One command at a time. Put char, newline without scroll: write, then finish.
// Read: registered RAM read, then capture. Remove: blank the cell, then split
// the index into row and column. With an index past the last cell, remove or
// read goes straight to finish. Scroll: one copied cell per cycle through the
// RAM's read and write ports. Clear: one blanked cell per cycle, then a prompt.
// Reset clears cursor and control; cells stay undefined until written.
// A stalled output word holds in the output register while the sequencer
// works on the next command; the sequencer waits only if its own word is done.
module text_console_writer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tcw_pkg::CMD_W-1:0]       command,
    input  logic [tcw_pkg::BYTE_W-1:0]      char_code,
    input  logic [tcw_pkg::BYTE_W-1:0]      colors,
    input  logic [tcw_pkg::BYTE_W-1:0]      blink_char,
    input  logic [tcw_pkg::INDEX_W-1:0]     cell_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tcw_pkg::CURSOR_W-1:0]    cursor_position,
    output logic [tcw_pkg::BYTE_W-1:0]      cell_char,
    output logic [tcw_pkg::BYTE_W-1:0]      cell_attr
);

    tcw_pkg::result_t                 res;
    logic                             res_ready;
    logic                             out_valid_reg, out_valid_next;
    logic [tcw_pkg::CURSOR_W-1:0]     cursor_reg;
    logic [tcw_pkg::BYTE_W-1:0]       char_reg;
    logic [tcw_pkg::BYTE_W-1:0]       attr_reg;

    tcw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .char_code  (char_code),
        .colors     (colors),
        .blink_char (blink_char),
        .cell_index (cell_index),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output slot is free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            cursor_reg <= res.cursor;
            char_reg   <= res.ch;
            attr_reg   <= res.attr;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_position = cursor_reg;
    assign cell_char       = char_reg;
    assign cell_attr       = attr_reg;

endmodule

// ----- sv/tcw_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer.
module tcw_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [tcw_pkg::CMD_W-1:0]       command,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [tcw_pkg::CURSOR_W-1:0]    cursor_position
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_position))
        else $error("output word changed while stalled");

    // one command at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a command is in progress");

    // a new output word is loaded only from the finishing state
    a_word_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("output word appeared without a command in progress");

    // clear sweeps the whole screen, so it must not finish early
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == tcw_pkg::CMD_CLEAR |=> ##1 !in_ready)
        else $error("clear finished too early");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_position (cursor_position)
);
